// File: design/assert_macros.svh
// Assertion macros shared by the rotator RTL.
// Each macro builds one labeled concurrent assertion on a clock and an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: design/irb_pkg.sv
// Shared types and constants for the bilinear image rotator.
// No dependencies; imported by the controller, datapath and top level.
package irb_pkg;

    localparam int DIMW  = 7;
    localparam int TRIGW = 16;
    localparam int PIXW  = 32;
    localparam int CFGW  = 16;
    localparam int CIDXW = 2;

    localparam logic [CIDXW-1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [CIDXW-1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [CIDXW-1:0] CFG_SINE       = 2'd2;
    localparam logic [CIDXW-1:0] CFG_COSINE     = 2'd3;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_RENDER = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       cap;
        logic       mul;
        logic       sum;
        logic       ofs;
        logic       rot;
        logic       src;
        logic       wgt;
        logic       rd_go;
        logic [1:0] rd_idx;
        logic       div_go;
        logic [2:0] div_bit;
    } irb_cmd_t;

endpackage

// File: design/irb_ctrl.sv
// Sequencer for the rotator: steps one render item through map, fetch and divide.
// Depends on irb_pkg for the command struct.
module irb_ctrl
    import irb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     func,
    output logic     busy,
    output logic     done,
    output irb_cmd_t cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_SUM  = 4'd2;
    localparam logic [3:0] S_OFS  = 4'd3;
    localparam logic [3:0] S_ROT  = 4'd4;
    localparam logic [3:0] S_SRC  = 4'd5;
    localparam logic [3:0] S_WGT  = 4'd6;
    localparam logic [3:0] S_RD   = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [2:0] k_reg, k_next;
    logic [2:0] bit_reg, bit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= 3'd0;
            bit_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            bit_reg   <= bit_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        bit_next   = bit_reg;
        cmd        = '0;
        cmd.rd_idx  = k_reg[1:0];
        cmd.div_bit = bit_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.cap = start;
                if (start && func == FUNC_RENDER)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_OFS;
            end
            S_OFS:
            begin
                cmd.ofs    = 1'b1;
                state_next = S_ROT;
            end
            S_ROT:
            begin
                cmd.rot    = 1'b1;
                state_next = S_SRC;
            end
            S_SRC:
            begin
                cmd.src    = 1'b1;
                state_next = S_WGT;
            end
            S_WGT:
            begin
                cmd.wgt    = 1'b1;
                k_next     = 3'd0;
                state_next = S_RD;
            end
            S_RD:
            begin
                // issue four reads, then a pass with no read drains the last accumulate
                cmd.rd_go = !k_reg[2];
                k_next    = k_reg + 3'd1;
                if (k_reg[2])
                begin
                    bit_next   = 3'd7;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_go = 1'b1;
                bit_next   = bit_reg - 3'd1;
                if (bit_reg == 3'd0)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_OUT);

endmodule

// File: design/irb_datapath.sv
// Datapath of the rotator: config registers, source store, inverse mapping,
// weighted accumulate and a four-lane restoring divider. Depends on irb_pkg.
module irb_datapath
    import irb_pkg::*;
#(
    parameter int MAX_DIM = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  irb_cmd_t         cmd,
    input  logic             func,
    input  logic [DIMW-1:0]  row,
    input  logic [DIMW-1:0]  col,
    input  logic [PIXW-1:0]  pixel_in,
    input  logic             cfg_we,
    input  logic [CIDXW-1:0] cfg_index,
    input  logic [CFGW-1:0]  cfg_data,
    output logic [PIXW-1:0]  pixel_out,
    output logic [DIMW-1:0]  out_width,
    output logic [DIMW-1:0]  out_height
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int ABSW  = 15;
    localparam int PRW   = DIMW + ABSW;
    localparam int RAWW  = PRW + 1;
    localparam int XTW   = 18;
    localparam int MW    = XTW + TRIGW;
    localparam int SXW   = 22;
    localparam int NXW   = SXW - 7;
    localparam int WTW   = 17;
    localparam int ACCW  = 25;

    // configuration
    logic [DIMW-1:0]         src_width_reg, src_height_reg;
    logic signed [TRIGW-1:0] sine_reg, cosine_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= 7'd64;
            src_height_reg <= 7'd64;
            sine_reg       <= 16'sd0;
            cosine_reg     <= 16'sd16384;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SRC_WIDTH:  src_width_reg  <= cfg_data[DIMW-1:0];
                CFG_SRC_HEIGHT: src_height_reg <= cfg_data[DIMW-1:0];
                CFG_SINE:       sine_reg       <= cfg_data;
                CFG_COSINE:     cosine_reg     <= cfg_data;
                default:        ;
            endcase
        end
    end

    function automatic logic [DIMW-1:0] clamp_dim(input logic [DIMW-1:0] v);
        logic [DIMW-1:0] r;
        r = v;
        if (v == '0)
            r = 7'd1;
        else if (int'(v) > MAX_DIM)
            r = DIMW'(MAX_DIM);
        return r;
    endfunction

    function automatic logic signed [TRIGW-1:0] clamp_trig(input logic signed [TRIGW-1:0] v);
        logic signed [TRIGW-1:0] r;
        r = v;
        if (v > 16'sd16384)
            r = 16'sd16384;
        else if (v < -16'sd16384)
            r = -16'sd16384;
        return r;
    endfunction

    logic [DIMW-1:0]         w_c, h_c;
    logic signed [TRIGW-1:0] s_c, c_c, s_neg, c_neg;
    logic [ABSW-1:0]         as_c, ac_c;

    assign w_c   = clamp_dim(src_width_reg);
    assign h_c   = clamp_dim(src_height_reg);
    assign s_c   = clamp_trig(sine_reg);
    assign c_c   = clamp_trig(cosine_reg);
    assign s_neg = -s_c;
    assign c_neg = -c_c;
    assign as_c  = s_c[TRIGW-1] ? s_neg[ABSW-1:0] : s_c[ABSW-1:0];
    assign ac_c  = c_c[TRIGW-1] ? c_neg[ABSW-1:0] : c_c[ABSW-1:0];

    // source store
    logic [PIXW-1:0] mem [DEPTH];
    logic [PIXW-1:0] rd_data_reg;
    logic [AW-1:0]   wr_addr, rd_addr;
    logic            wr_en;

    assign wr_en   = cmd.cap && (func == FUNC_LOAD) && (int'(row) < MAX_DIM)
                     && (int'(col) < MAX_DIM);
    assign wr_addr = AW'(AW'(row) * AW'(MAX_DIM) + AW'(col));

    // capture
    logic [DIMW-1:0] row_reg, col_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            row_reg <= row;
            col_reg <= col;
        end
    end

    // output size
    logic [PRW-1:0]  p_wa_reg, p_hs_reg, p_ws_reg, p_ha_reg;
    logic [RAWW-1:0] raw_w_reg, raw_h_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            p_wa_reg <= PRW'(w_c * ac_c);
            p_hs_reg <= PRW'(h_c * as_c);
            p_ws_reg <= PRW'(w_c * as_c);
            p_ha_reg <= PRW'(h_c * ac_c);
        end
        if (cmd.sum)
        begin
            raw_w_reg <= RAWW'(p_wa_reg) + RAWW'(p_hs_reg);
            raw_h_reg <= RAWW'(p_ws_reg) + RAWW'(p_ha_reg);
        end
    end

    function automatic logic [DIMW-1:0] round_size(input logic [RAWW-1:0] v);
        logic [RAWW:0] t;
        t = (RAWW+1)'(v) + (RAWW+1)'(8192);
        return (t[RAWW:14] > 127) ? 7'd127 : t[20:14];
    endfunction

    assign out_width  = round_size(raw_w_reg);
    assign out_height = round_size(raw_h_reg);

    // inverse mapping
    logic signed [XTW-1:0] xt_reg, yt_reg;
    logic signed [MW-1:0]  m_xc_reg, m_ys_reg, m_xs_reg, m_yc_reg;
    logic signed [SXW-1:0] sx_reg, sy_reg;
    logic signed [MW:0]    dx, dy;
    logic signed [SXW-1:0] hoff, woff;

    assign dx   = (MW+1)'(m_xc_reg) - (MW+1)'(m_ys_reg);
    assign dy   = (MW+1)'(m_xs_reg) + (MW+1)'(m_yc_reg);
    assign hoff = signed'(SXW'({h_c - 7'd1, 7'd0}));
    assign woff = signed'(SXW'({w_c - 7'd1, 7'd0}));

    always_ff @(posedge clk)
    begin
        if (cmd.ofs)
        begin
            xt_reg <= signed'(XTW'({row_reg, 9'd0})) - signed'(XTW'(raw_h_reg[RAWW-1:6]))
                      + 18'sd256;
            yt_reg <= signed'(XTW'({col_reg, 9'd0})) - signed'(XTW'(raw_w_reg[RAWW-1:6]))
                      + 18'sd256;
        end
        if (cmd.rot)
        begin
            m_xc_reg <= xt_reg * c_c;
            m_ys_reg <= yt_reg * s_c;
            m_xs_reg <= xt_reg * s_c;
            m_yc_reg <= yt_reg * c_c;
        end
        if (cmd.src)
        begin
            sx_reg <= SXW'(dx >>> 15) + hoff;
            sy_reg <= SXW'(dy >>> 15) + woff;
        end
    end

    // weights
    logic [7:0]      fx, fy;
    logic [8:0]      fx9, fy9, gx9, gy9;
    logic [WTW-1:0]  wt_reg [4];

    assign fx  = sx_reg[7:0];
    assign fy  = sy_reg[7:0];
    assign fx9 = {1'b0, fx};
    assign fy9 = {1'b0, fy};
    assign gx9 = 9'd256 - fx9;
    assign gy9 = 9'd256 - fy9;

    always_ff @(posedge clk)
    begin
        if (cmd.wgt)
        begin
            wt_reg[0] <= WTW'(gx9 * gy9);
            wt_reg[1] <= WTW'(gx9 * fy9);
            wt_reg[2] <= WTW'(fx9 * gy9);
            wt_reg[3] <= WTW'(fx9 * fy9);
        end
    end

    // neighbor fetch
    logic signed [NXW-1:0] nx, ny;
    logic                  nb_ok;

    assign nx    = NXW'(sx_reg >>> 8) + NXW'(cmd.rd_idx[1]);
    assign ny    = NXW'(sy_reg >>> 8) + NXW'(cmd.rd_idx[0]);
    assign nb_ok = (nx >= 0) && (nx < signed'(NXW'(h_c)))
                   && (ny >= 0) && (ny < signed'(NXW'(w_c)));
    assign rd_addr = AW'(AW'(unsigned'(nx)) * AW'(MAX_DIM) + AW'(unsigned'(ny)));

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= pixel_in;
        if (cmd.rd_go)
            rd_data_reg <= mem[rd_addr];
    end

    logic            pend_reg;
    logic [WTW-1:0]  pwt_reg;
    logic [ACCW-1:0] acc_reg [4];
    logic [WTW-1:0]  total_reg;
    logic [7:0]      q_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 1'b0;
        else
            pend_reg <= cmd.rd_go && nb_ok;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_go)
            pwt_reg <= wt_reg[cmd.rd_idx];
        if (cmd.wgt)
        begin
            total_reg <= '0;
            for (int i = 0; i < 4; i++)
                acc_reg[i] <= '0;
        end
        else if (pend_reg)
        begin
            total_reg <= total_reg + pwt_reg;
            for (int i = 0; i < 4; i++)
                acc_reg[i] <= acc_reg[i] + ACCW'(pwt_reg * rd_data_reg[8*i +: 8]);
        end
        else if (cmd.div_go)
        begin
            // one quotient bit per lane, quotient known to fit in eight bits
            for (int i = 0; i < 4; i++)
            begin
                if (acc_reg[i] >= (ACCW'(total_reg) << cmd.div_bit))
                begin
                    acc_reg[i] <= acc_reg[i] - (ACCW'(total_reg) << cmd.div_bit);
                    q_reg[i][cmd.div_bit] <= 1'b1;
                end
                else
                begin
                    q_reg[i][cmd.div_bit] <= 1'b0;
                end
            end
        end
    end

    assign pixel_out = (total_reg == '0) ? '0 : {q_reg[3], q_reg[2], q_reg[1], q_reg[0]};

endmodule

// File: design/image_rotate_bilinear_top.sv
// Top level of the bilinear image rotator.
// Depends on irb_pkg, irb_ctrl, irb_datapath and assert_macros.svh.
//
// Usage:
//   Command channel: raise start with func, row, col and pixel_in; the item is
//   taken at a clock edge where start is high and busy is low.
//   A load item (func 0) writes pixel_in into the source store in that same
//   edge and leaves busy low, so loads stream at one item per cycle. Loads at
//   row or col beyond MAX_DIM-1 are dropped.
//   A render item (func 1) raises busy while the sequencer forms the size
//   products, offsets and inverse rotation, fetches the four neighbors through
//   the single store read port, runs the four-lane restoring divider and then
//   shows the result. done pulses for a single cycle at the end with pixel_out,
//   out_width and out_height; the next item is taken once busy is low again.
//   Results cannot be held off; take them on the done cycle.
//   Configuration: cfg_we writes cfg_data to register cfg_index (0 width,
//   1 height, 2 sine, 3 cosine) at a clock edge; write only while idle.
//   Reset clears the sequencer and loads the register defaults; the source
//   store is not cleared and must be loaded before rendering from it.
`include "assert_macros.svh"

module image_rotate_bilinear_top
    import irb_pkg::*;
#(
    parameter int MAX_DIM = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             func,
    input  logic [DIMW-1:0]  row,
    input  logic [DIMW-1:0]  col,
    input  logic [PIXW-1:0]  pixel_in,
    output logic             done,
    output logic [PIXW-1:0]  pixel_out,
    output logic [DIMW-1:0]  out_width,
    output logic [DIMW-1:0]  out_height,
    input  logic             cfg_we,
    input  logic [CIDXW-1:0] cfg_index,
    input  logic [CFGW-1:0]  cfg_data
);

    irb_cmd_t cmd;

    // sequence the render steps
    irb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // hold config, store, mapping and division
    irb_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .func       (func),
        .row        (row),
        .col        (col),
        .pixel_in   (pixel_in),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pixel_out  (pixel_out),
        .out_width  (out_width),
        .out_height (out_height)
    );

    `ASSERT_NEXT(a_load_stays_idle, clk, rst_n, start && !busy && !func, !busy && !done)
    `ASSERT_NEXT(a_render_goes_busy, clk, rst_n, start && !busy && func, busy && !done)
    `ASSERT_NEXT(a_done_releases, clk, rst_n, done, !busy && !done)
    `ASSERT_IMPLY(a_done_while_busy, clk, rst_n, done, busy && $past(busy))

endmodule
